// ===== design/xtea_pkg.sv =====
// Shared types, constants and the round mixing function for the XTEA cipher core.
// No dependencies.
`default_nettype none

package xtea_pkg;

  localparam int WORD_W = 32;
  localparam int KEY_COUNT = 4;
  localparam int KEY_IDX_W = 2;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t DELTA = 32'h9E37_79B9;

  function automatic word_t mix_word(input word_t w);
    return ((w << 4) ^ (w >> 5)) + w;
  endfunction

endpackage

`default_nettype wire

// ===== design/xtea_block_cipher_core.sv =====
// XTEA block cipher core: fully unrolled half-round pipeline with a two-entry output buffer.
// Depends on xtea_pkg.
`default_nettype none

// One 64-bit block enters per cycle while in_tready is high (in_tdata = {second, first},
// in_tuser = 1 for decrypt) and leaves through the output register. Each Feistel half-round
// takes two pipeline stages: one forms the keyed mix term, the next adds or subtracts it. The
// two-entry output buffer lets one result wait at the output while the pipeline keeps
// accepting; in_tready drops only when both entries are occupied. The key registers are
// written through cfg_we/cfg_index/cfg_wdata and must only be changed while no block is in
// flight.
module xtea_block_cipher_core #(
  parameter int CYCLE_COUNT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] block_first, [63:32] block_second
  input  wire logic        in_tuser,   // [0] action (0 encrypt, 1 decrypt)
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata   // [31:0] result_first, [63:32] result_second
);

  localparam int HALF_COUNT = 2 * CYCLE_COUNT;

  xtea_pkg::word_t key_r [0:xtea_pkg::KEY_COUNT-1];

  // full-word stages: index 0 is the input register, h+1 follows half-round h
  xtea_pkg::word_t v0_r  [0:HALF_COUNT];
  xtea_pkg::word_t v1_r  [0:HALF_COUNT];
  logic            dec_r [0:HALF_COUNT];
  logic            vld_r [0:HALF_COUNT];

  // mid stages of each half-round
  xtea_pkg::word_t av0_r  [0:HALF_COUNT-1];
  xtea_pkg::word_t av1_r  [0:HALF_COUNT-1];
  xtea_pkg::word_t at_r   [0:HALF_COUNT-1];
  logic            adec_r [0:HALF_COUNT-1];
  logic            avld_r [0:HALF_COUNT-1];

  logic            out_valid_r;
  logic [63:0]     out_data_r;
  logic            skid_valid_r;
  logic [63:0]     skid_data_r;

  logic en;
  logic push;
  logic pop;

  assign en        = !skid_valid_r;
  assign in_tready = en;
  assign push      = en && vld_r[HALF_COUNT];
  assign pop       = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < xtea_pkg::KEY_COUNT; k++) begin
        key_r[k] <= '0;
      end
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0_r[0]  <= in_tdata[31:0];
      v1_r[0]  <= in_tdata[63:32];
      dec_r[0] <= in_tuser;
    end
  end

  for (genvar h = 0; h < HALF_COUNT; h++) begin : g_half
    localparam bit EVEN = (h % 2) == 0;
    localparam xtea_pkg::word_t SUM_E = 32'((h + 1) / 2) * xtea_pkg::DELTA;
    localparam xtea_pkg::word_t SUM_D = 32'(CYCLE_COUNT - (h + 1) / 2) * xtea_pkg::DELTA;
    localparam logic [1:0] SEL_E = EVEN ? SUM_E[1:0] : SUM_E[12:11];
    localparam logic [1:0] SEL_D = EVEN ? SUM_D[12:11] : SUM_D[1:0];

    logic            a_to_v0;
    xtea_pkg::word_t a_src;
    xtea_pkg::word_t a_sum;
    xtea_pkg::word_t a_key;
    xtea_pkg::word_t a_term_nxt;

    logic            b_to_v0;
    xtea_pkg::word_t b_tgt;
    xtea_pkg::word_t b_word_nxt;

    // the updated word is v0 on encrypt-even and decrypt-odd half-rounds
    assign a_to_v0    = EVEN ^ dec_r[h];
    assign a_src      = a_to_v0 ? v1_r[h] : v0_r[h];
    assign a_sum      = dec_r[h] ? SUM_D : SUM_E;
    assign a_key      = dec_r[h] ? key_r[SEL_D] : key_r[SEL_E];
    assign a_term_nxt = xtea_pkg::mix_word(a_src) ^ (a_sum + a_key);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        avld_r[h] <= 1'b0;
      end else if (en) begin
        avld_r[h] <= vld_r[h];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        av0_r[h]  <= v0_r[h];
        av1_r[h]  <= v1_r[h];
        at_r[h]   <= a_term_nxt;
        adec_r[h] <= dec_r[h];
      end
    end

    assign b_to_v0    = EVEN ^ adec_r[h];
    assign b_tgt      = b_to_v0 ? av0_r[h] : av1_r[h];
    assign b_word_nxt = adec_r[h] ? (b_tgt - at_r[h]) : (b_tgt + at_r[h]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[h+1] <= 1'b0;
      end else if (en) begin
        vld_r[h+1] <= avld_r[h];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v0_r[h+1]  <= b_to_v0 ? b_word_nxt : av0_r[h];
        v1_r[h+1]  <= b_to_v0 ? av1_r[h] : b_word_nxt;
        dec_r[h+1] <= adec_r[h];
      end
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_valid_r || pop) begin
      out_data_r <= {v1_r[HALF_COUNT], v0_r[HALF_COUNT]};
    end else begin
      skid_data_r <= {v1_r[HALF_COUNT], v0_r[HALF_COUNT]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== design/xtea_chk.sv =====
// Port-level checker for the XTEA cipher core, bound into xtea_block_cipher_core.
// Depends on xtea_block_cipher_core ports only.
`default_nettype none

module xtea_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready
);

  // a waiting result transaction is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before transaction");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // backpressure only with a result waiting at the output
  a_stall_has_out: assert property (@(posedge clk)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without a held result");

endmodule

bind xtea_block_cipher_core xtea_chk u_xtea_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

// ===== tb/tb_xtea_block_cipher_core.sv =====
// Self-checking testbench for xtea_block_cipher_core: drives directed and random 64-bit blocks
// under several keys, checks every result against a behavioral XTEA model; depends on xtea_pkg and the core RTL.
module tb_xtea_block_cipher_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROUNDS      = 32;
  localparam int IDLE_LIMIT  = 3000;
  localparam int LONG_STALL  = 400;
  localparam int PRINT_LIMIT = 200;

  typedef struct packed {
    logic            decrypt;
    xtea_pkg::word_t first;
    xtea_pkg::word_t second;
  } cipher_req_t;

  typedef struct packed {
    xtea_pkg::word_t first;
    xtea_pkg::word_t second;
  } cipher_block_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [31:0] block_first, [63:32] block_second
  logic        in_tuser = 1'b0; // [0] action (0 encrypt, 1 decrypt)
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [31:0] result_first, [63:32] result_second

  cipher_req_t     blocks_to_cipher[$];
  cipher_block_t   expected_blocks[$];
  xtea_pkg::word_t key_copy[xtea_pkg::KEY_COUNT] = '{default: '0};

  int error_count = 0;
  int idle_cycles = 0;
  bit in_taken = 0;
  bit out_taken = 0;
  bit in_random_gaps = 1;
  bit out_random_gaps = 1;
  bit long_stall_req = 0;
  int in_gap = 0;
  int out_gap = 0;
  int stall_cnt = 0;

  xtea_block_cipher_core #(.CYCLE_COUNT(ROUNDS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic xtea_pkg::word_t feistel_f(xtea_pkg::word_t w);
    return ((w << 4) ^ (w >> 5)) + w;
  endfunction

  function automatic cipher_block_t xtea_transform(logic decrypt, xtea_pkg::word_t v0_in,
                                                   xtea_pkg::word_t v1_in);
    xtea_pkg::word_t v0;
    xtea_pkg::word_t v1;
    xtea_pkg::word_t acc;
    cipher_block_t   res;
    v0 = v0_in;
    v1 = v1_in;
    if (!decrypt) begin
      acc = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        v0 += feistel_f(v1) ^ (acc + key_copy[acc[1:0]]);
        acc += xtea_pkg::DELTA;
        v1 += feistel_f(v0) ^ (acc + key_copy[acc[12:11]]);
      end
    end else begin
      acc = xtea_pkg::word_t'(ROUNDS) * xtea_pkg::DELTA;
      for (int r = 0; r < ROUNDS; r++) begin
        v1 -= feistel_f(v0) ^ (acc + key_copy[acc[12:11]]);
        acc -= xtea_pkg::DELTA;
        v0 -= feistel_f(v1) ^ (acc + key_copy[acc[1:0]]);
      end
    end
    res.first  = v0;
    res.second = v1;
    return res;
  endfunction

  function automatic int draw_gap(bit random_gaps);
    if (!random_gaps || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic xtea_pkg::word_t rand_word();
    int k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return xtea_pkg::word_t'(1) << k;
      3:       return ~(xtea_pkg::word_t'(1) << k);
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(string msg);
    if (error_count < PRINT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic queue_block(logic decrypt, xtea_pkg::word_t first, xtea_pkg::word_t second);
    cipher_req_t req;
    req.decrypt = decrypt;
    req.first   = first;
    req.second  = second;
    blocks_to_cipher.push_back(req);
  endtask

  task automatic wait_drained();
    while (blocks_to_cipher.size() != 0 || in_tvalid || expected_blocks.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_key(xtea_pkg::word_t k0, xtea_pkg::word_t k1, xtea_pkg::word_t k2,
                          xtea_pkg::word_t k3);
    xtea_pkg::word_t kw[xtea_pkg::KEY_COUNT];
    kw = '{k0, k1, k2, k3};
    for (int i = 0; i < xtea_pkg::KEY_COUNT; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= kw[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sampling, prediction and checking
  always @(posedge clk) begin
    cipher_block_t want;
    if (rst_n) begin
      if (cfg_we) key_copy[cfg_index] = cfg_wdata;
      if (in_tvalid && in_tready) begin
        in_taken = 1;
        expected_blocks.push_back(xtea_transform(in_tuser, in_tdata[31:0], in_tdata[63:32]));
      end
      if (out_tvalid && out_tready) begin
        out_taken = 1;
        if (expected_blocks.size() == 0) begin
          report_error($sformatf("unexpected result %h", out_tdata));
        end else begin
          want = expected_blocks.pop_front();
          if (out_tdata[31:0] !== want.first)
            report_error($sformatf("result_first got %h want %h", out_tdata[31:0], want.first));
          if (out_tdata[63:32] !== want.second)
            report_error($sformatf("result_second got %h want %h", out_tdata[63:32],
                                   want.second));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_xtea_block_cipher_core failed");
        $finish;
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    cipher_req_t req;
    logic        next_valid;
    if (rst_n) begin
      next_valid = in_tvalid && !in_taken;
      in_taken = 0;
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (blocks_to_cipher.size() != 0) begin
          req = blocks_to_cipher.pop_front();
          in_tdata   <= {req.second, req.first};
          in_tuser   <= req.decrypt;
          next_valid = 1'b1;
          in_gap     = draw_gap(in_random_gaps);
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (long_stall_req) begin
        stall_cnt = LONG_STALL;
        long_stall_req = 0;
      end
      if (out_taken) begin
        out_taken = 0;
        out_gap = draw_gap(out_random_gaps);
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    xtea_pkg::word_t k[xtea_pkg::KEY_COUNT];
    int              n_items;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset key, field extremes, both directions
    for (int d = 0; d < 2; d++) begin
      queue_block(d[0], 32'h0000_0000, 32'h0000_0000);
      queue_block(d[0], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_block(d[0], 32'h0000_0000, 32'hFFFF_FFFF);
      queue_block(d[0], 32'hFFFF_FFFF, 32'h0000_0000);
      queue_block(d[0], 32'h8000_0000, 32'h0000_0001);
      queue_block(d[0], 32'hAAAA_AAAA, 32'h5555_5555);
    end
    wait_drained();

    // directed: all-ones key
    load_key('1, '1, '1, '1);
    for (int d = 0; d < 2; d++) begin
      queue_block(d[0], 32'h0000_0000, 32'h0000_0000);
      queue_block(d[0], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_block(d[0], 32'h4142_4344, 32'h4546_4748);
      queue_block(d[0], 32'h0000_0001, 32'h8000_0000);
    end
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       k = '{32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F};
        2:       k = '{'1, '0, '1, '0};
        5:       k = '{'0, '0, '0, '0};
        7:       k = '{'1, '1, '1, '1};
        default: k = '{rand_word(), rand_word(), rand_word(), rand_word()};
      endcase
      load_key(k[0], k[1], k[2], k[3]);
      in_random_gaps  = $urandom_range(0, 2) != 0;
      out_random_gaps = $urandom_range(0, 2) != 0;
      n_items = 110;
      if (p == 3) begin
        // back up the pipeline behind a held-off receiver
        in_random_gaps = 0;
        out_random_gaps = 0;
        long_stall_req = 1;
        n_items = 300;
      end
      for (int i = 0; i < n_items; i++)
        queue_block(1'($urandom_range(0, 1)), rand_word(), rand_word());
      wait_drained();
    end

    repeat (150) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_xtea_block_cipher_core passed");
    end else begin
      $display("tb_xtea_block_cipher_core failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/xtea_pkg.sv
design/xtea_block_cipher_core.sv
design/xtea_chk.sv
tb/tb_xtea_block_cipher_core.sv
